// File: rtl/core/srtk_pkg.sv
`default_nettype none
package srtk_pkg;

	localparam int unsigned KEY_W        = 32;
	localparam int unsigned OP_W         = 2;
	localparam int unsigned ST_W         = 3;
	localparam int unsigned POS_W        = 4;
	localparam int unsigned DEF_CAPACITY = 16;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_READ   = 2'd2
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK       = 3'd0,
		ST_DUP      = 3'd1,
		ST_FULL     = 3'd2,
		ST_NOTFOUND = 3'd3,
		ST_EMPTY    = 3'd4
	} status_t;

	typedef struct packed {
		op_t                     op;
		logic signed [KEY_W-1:0] key;
	} cmd_t;

endpackage
`default_nettype wire

// File: rtl/core/srtk_if.sv
`default_nettype none
interface srtk_req_if;
	import srtk_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [OP_W-1:0]         op;
	logic signed [KEY_W-1:0] key;

	modport source (output valid, output op, output key, input ready);
	modport sink   (input valid, input op, input key, output ready);
endinterface

interface srtk_rsp_if;
	import srtk_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [ST_W-1:0]         status;
	logic signed [KEY_W-1:0] key_out;
	logic [POS_W-1:0]        position;
	logic                    last;

	modport source (output valid, output status, output key_out, output position,
		output last, input ready);
	modport sink   (input valid, input status, input key_out, input position,
		input last, output ready);
endinterface
`default_nettype wire

// File: rtl/core/srtk_front.sv
`default_nettype none
module srtk_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	srtk_req_if.sink              req,
	output logic                  cmd_valid,
	output srtk_pkg::cmd_t        cmd,
	input  wire logic             cmd_pop
);
	import srtk_pkg::*;

	cmd_t       q_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       known_op;
	logic       push;

	// unused op code is taken and dropped here
	assign known_op = (req.op == OP_INSERT) || (req.op == OP_DELETE) || (req.op == OP_READ);
	assign req.ready = (fill_q != 2'd2);
	assign push = req.valid && req.ready && known_op;

	assign cmd_valid = (fill_q != 2'd0);
	assign cmd = q_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wr_ptr_q] <= '{op: op_t'(req.op), key: req.key};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (cmd_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, cmd_pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/srtk_back.sv
`default_nettype none
module srtk_back #(
	parameter int unsigned CAPACITY = srtk_pkg::DEF_CAPACITY
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cmd_valid,
	input  wire srtk_pkg::cmd_t   cmd,
	output logic                  cmd_pop,
	srtk_rsp_if.source            rsp
);
	import srtk_pkg::*;

	localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

	typedef enum logic [9:0] {
		S_IDLE     = 10'b0000000001,
		S_SRCH_RD  = 10'b0000000010,
		S_SRCH_CMP = 10'b0000000100,
		S_DECIDE   = 10'b0000001000,
		S_SHIFT_RD = 10'b0000010000,
		S_SHIFT_WR = 10'b0000100000,
		S_PUT_KEY  = 10'b0001000000,
		S_RESP     = 10'b0010000000,
		S_RD_RD    = 10'b0100000000,
		S_RD_EMIT  = 10'b1000000000
	} state_t;

	state_t                  state_q;
	op_t                     op_q;
	logic signed [KEY_W-1:0] key_q;
	logic [CNT_W-1:0]        n_q;
	logic [CNT_W-1:0]        idx_q;
	logic [CNT_W-1:0]        j_q;
	logic                    hit_q;
	logic [CNT_W-1:0]        count_q;
	status_t                 res_st_q;
	logic [POS_W-1:0]        res_pos_q;

	logic                    out_valid_q;
	status_t                 out_st_q;
	logic signed [KEY_W-1:0] out_key_q;
	logic [POS_W-1:0]        out_pos_q;
	logic                    out_last_q;

	logic signed [KEY_W-1:0] mem [CAPACITY];
	logic signed [KEY_W-1:0] rdata_q;
	logic                    mem_re;
	logic                    mem_we;
	logic [IDX_W-1:0]        mem_raddr;
	logic [IDX_W-1:0]        mem_waddr;
	logic signed [KEY_W-1:0] mem_wdata;

	logic [CNT_W-1:0]        j_m1;
	logic [CNT_W-1:0]        j_p1;
	logic [CNT_W-1:0]        idx_p1;
	logic                    slot_free;
	logic                    out_load;
	logic                    is_ins;

	assign j_m1      = j_q - 1'b1;
	assign j_p1      = j_q + 1'b1;
	assign idx_p1    = idx_q + 1'b1;
	assign is_ins    = (op_q == OP_INSERT);
	assign slot_free = !out_valid_q || rsp.ready;
	assign out_load  = slot_free && ((state_q == S_RESP) || (state_q == S_RD_EMIT));
	assign cmd_pop   = (state_q == S_IDLE) && cmd_valid;

	assign rsp.valid    = out_valid_q;
	assign rsp.status   = out_st_q;
	assign rsp.key_out  = out_key_q;
	assign rsp.position = out_pos_q;
	assign rsp.last     = out_last_q;

	always_comb begin
		mem_re    = 1'b0;
		mem_we    = 1'b0;
		mem_raddr = idx_q[IDX_W-1:0];
		mem_waddr = j_q[IDX_W-1:0];
		mem_wdata = rdata_q;
		case (state_q)
			S_SRCH_RD: mem_re = (idx_q != n_q);
			S_RD_RD:   mem_re = 1'b1;
			S_SHIFT_RD: begin
				mem_re    = 1'b1;
				mem_raddr = is_ins ? j_m1[IDX_W-1:0] : j_p1[IDX_W-1:0];
			end
			S_SHIFT_WR: mem_we = 1'b1;
			S_PUT_KEY: begin
				mem_we    = 1'b1;
				mem_waddr = idx_q[IDX_W-1:0];
				mem_wdata = key_q;
			end
			default: mem_re = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= OP_INSERT;
			key_q       <= '0;
			n_q         <= '0;
			idx_q       <= '0;
			j_q         <= '0;
			hit_q       <= 1'b0;
			count_q     <= '0;
			res_st_q    <= ST_OK;
			res_pos_q   <= '0;
			out_valid_q <= 1'b0;
			out_st_q    <= ST_OK;
			out_key_q   <= '0;
			out_pos_q   <= '0;
			out_last_q  <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						op_q  <= cmd.op;
						key_q <= cmd.key;
						n_q   <= count_q;
						idx_q <= '0;
						hit_q <= 1'b0;
						if (cmd.op == OP_READ) begin
							if (count_q == '0) begin
								res_st_q  <= ST_EMPTY;
								res_pos_q <= '0;
								state_q   <= S_RESP;
							end else begin
								state_q <= S_RD_RD;
							end
						end else begin
							state_q <= S_SRCH_RD;
						end
					end
				end
				S_SRCH_RD: begin
					state_q <= (idx_q == n_q) ? S_DECIDE : S_SRCH_CMP;
				end
				S_SRCH_CMP: begin
					// insert stops at the first key not below; delete at an exact match
					if (is_ins ? (rdata_q >= key_q) : (rdata_q == key_q)) begin
						hit_q   <= (rdata_q == key_q);
						state_q <= S_DECIDE;
					end else begin
						idx_q   <= idx_p1;
						state_q <= S_SRCH_RD;
					end
				end
				S_DECIDE: begin
					j_q <= is_ins ? n_q : idx_q;
					if (is_ins) begin
						if (hit_q) begin
							res_st_q  <= ST_DUP;
							res_pos_q <= POS_W'(idx_q);
							state_q   <= S_RESP;
						end else if (n_q == CNT_W'(CAPACITY)) begin
							res_st_q  <= ST_FULL;
							res_pos_q <= '0;
							state_q   <= S_RESP;
						end else begin
							res_st_q  <= ST_OK;
							res_pos_q <= POS_W'(idx_q);
							count_q   <= n_q + 1'b1;
							state_q   <= (n_q > idx_q) ? S_SHIFT_RD : S_PUT_KEY;
						end
					end else begin
						if (n_q == '0) begin
							res_st_q  <= ST_EMPTY;
							res_pos_q <= '0;
							state_q   <= S_RESP;
						end else if (!hit_q) begin
							res_st_q  <= ST_NOTFOUND;
							res_pos_q <= '0;
							state_q   <= S_RESP;
						end else begin
							res_st_q  <= ST_OK;
							res_pos_q <= POS_W'(idx_q);
							count_q   <= n_q - 1'b1;
							state_q   <= (idx_p1 < n_q) ? S_SHIFT_RD : S_RESP;
						end
					end
				end
				S_SHIFT_RD: begin
					state_q <= S_SHIFT_WR;
				end
				S_SHIFT_WR: begin
					// insert moves words up from the top, delete moves them down
					if (is_ins) begin
						j_q     <= j_m1;
						state_q <= (j_m1 > idx_q) ? S_SHIFT_RD : S_PUT_KEY;
					end else begin
						j_q     <= j_p1;
						state_q <= ((j_p1 + 1'b1) < n_q) ? S_SHIFT_RD : S_RESP;
					end
				end
				S_PUT_KEY: begin
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (slot_free) begin
						out_st_q    <= res_st_q;
						out_key_q   <= key_q;
						out_pos_q   <= res_pos_q;
						out_last_q  <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				S_RD_RD: begin
					state_q <= S_RD_EMIT;
				end
				S_RD_EMIT: begin
					if (slot_free) begin
						out_st_q    <= ST_OK;
						out_key_q   <= rdata_q;
						out_pos_q   <= POS_W'(idx_q);
						out_last_q  <= (idx_p1 == n_q);
						idx_q       <= idx_p1;
						state_q     <= (idx_p1 == n_q) ? S_IDLE : S_RD_RD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/sorted_unique_key_list.sv
// channel | dir | words               | payload
// req     | in  | one per operation   | op, key
// rsp     | out | 1, or n on readout  | status, key_out, position, last
//
// Insert/delete: a read and a compare step per key scanned, then a read and a write step
// per key moved, as the single-port key store gives one registered read per step.
// Readout: a read step and an emit step per stored word, same store port.
// Reset clears the entry count and queues; the store itself is not cleared.
// A two-word queue takes requests while the engine works; rsp is registered.
// A stalled rsp holds the engine at its emit step; the queue then fills and drops req.ready.
`default_nettype none
module sorted_unique_key_list #(
	parameter int unsigned CAPACITY = srtk_pkg::DEF_CAPACITY
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	srtk_req_if.sink    req,
	srtk_rsp_if.source  rsp
);
	import srtk_pkg::*;

	logic cmd_valid;
	cmd_t cmd;
	logic cmd_pop;

	srtk_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	srtk_back #(
		.CAPACITY (CAPACITY)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.rsp       (rsp)
	);

endmodule
`default_nettype wire

// File: dv/sorted_unique_key_list_test.sv
`timescale 1ns / 1ps
module sorted_unique_key_list_test;
	import srtk_pkg::*;

	localparam int          CAPACITY   = DEF_CAPACITY;
	localparam int          ITEMS      = 360;
	localparam int          HOLD_LEN   = 400;
	localparam int          DRAIN_WAIT = 200;
	localparam logic [1:0]  OP_UNUSED  = 2'd3;

	typedef struct packed {
		status_t                 status;
		logic signed [KEY_W-1:0] key_out;
		logic [POS_W-1:0]        position;
		logic                    last;
	} rsp_word_t;

	typedef struct {
		logic [OP_W-1:0]         op;
		logic signed [KEY_W-1:0] key;
		bit                      typed;
		status_t                 status;
		logic [POS_W-1:0]        position;
	} cmd_row_t;

	// typed rows: errors, extremes and the state just after reset
	cmd_row_t script [0:26] = '{
		'{OP_READ,   32'sd5,          1'b1, ST_EMPTY,    4'd0},
		'{OP_DELETE, 32'sd0,          1'b1, ST_EMPTY,    4'd0},
		'{OP_UNUSED, -32'sd1,         1'b0, ST_OK,       4'd0},
		'{OP_INSERT, 32'sh7FFFFFFF,   1'b1, ST_OK,       4'd0},
		'{OP_INSERT, 32'sh80000000,   1'b1, ST_OK,       4'd0},
		'{OP_INSERT, 32'sd0,          1'b1, ST_OK,       4'd1},
		'{OP_INSERT, 32'sd0,          1'b1, ST_DUP,      4'd1},
		'{OP_DELETE, 32'sd12345,      1'b1, ST_NOTFOUND, 4'd0},
		'{OP_DELETE, 32'sh80000000,   1'b1, ST_OK,       4'd0},
		'{OP_READ,   32'sd0,          1'b0, ST_OK,       4'd0},
		'{OP_INSERT, 32'sd1,          1'b0, ST_OK,       4'd0},
		'{OP_INSERT, 32'sd2,          1'b0, ST_OK,       4'd0},
		'{OP_INSERT, 32'sd3,          1'b0, ST_OK,       4'd0},
		'{OP_INSERT, 32'sd4,          1'b0, ST_OK,       4'd0},
		'{OP_INSERT, 32'sd5,          1'b0, ST_OK,       4'd0},
		'{OP_INSERT, 32'sd6,          1'b0, ST_OK,       4'd0},
		'{OP_INSERT, 32'sd7,          1'b0, ST_OK,       4'd0},
		'{OP_INSERT, 32'sd8,          1'b0, ST_OK,       4'd0},
		'{OP_INSERT, 32'sd9,          1'b0, ST_OK,       4'd0},
		'{OP_INSERT, 32'sd10,         1'b0, ST_OK,       4'd0},
		'{OP_INSERT, 32'sd11,         1'b0, ST_OK,       4'd0},
		'{OP_INSERT, 32'sd12,         1'b0, ST_OK,       4'd0},
		'{OP_INSERT, 32'sd13,         1'b0, ST_OK,       4'd0},
		'{OP_INSERT, 32'sd14,         1'b0, ST_OK,       4'd0},
		'{OP_INSERT, 32'sd100,        1'b1, ST_FULL,     4'd0},
		'{OP_INSERT, 32'sd5,          1'b1, ST_DUP,      4'd5},
		'{OP_READ,   -32'sd7,         1'b0, ST_OK,       4'd0}
	};

	logic clk = 1'b0;
	logic arst_n;

	srtk_req_if req_ch ();
	srtk_rsp_if rsp_ch ();

	sorted_unique_key_list dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always #10 clk = ~clk;

	logic signed [KEY_W-1:0] key_store [0:CAPACITY-1];
	int                      key_cnt;
	logic signed [KEY_W-1:0] key_pool [0:23];
	rsp_word_t               fresh_rsp [$];
	rsp_word_t               words_due [$];
	rsp_word_t               word_due;

	int err_cnt;
	int n_words;
	int n_cmds;
	int n_ignored;
	int n_reads;
	int n_full;
	int peak_fill;
	bit hold_req;
	bit hold_done;

	task automatic report_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $time, msg);
		err_cnt++;
	endtask

	// expected words for one command, pushed to fresh_rsp; updates the key set
	function automatic void predict_cmd(input logic [OP_W-1:0] op,
			input logic signed [KEY_W-1:0] key);
		int        r;
		int        i;
		rsp_word_t w;
		w.status   = ST_OK;
		w.key_out  = key;
		w.position = '0;
		w.last     = 1'b1;
		case (op)
			OP_INSERT: begin
				r = 0;
				while (r < key_cnt && key_store[r] < key)
					r++;
				if (r < key_cnt && key_store[r] == key) begin
					w.status   = ST_DUP;
					w.position = r[POS_W-1:0];
				end else if (key_cnt >= CAPACITY) begin
					w.status = ST_FULL;
				end else begin
					for (i = key_cnt; i > r; i--)
						key_store[i] = key_store[i-1];
					key_store[r] = key;
					key_cnt++;
					w.position = r[POS_W-1:0];
				end
				fresh_rsp.push_back(w);
			end
			OP_DELETE: begin
				if (key_cnt == 0) begin
					w.status = ST_EMPTY;
				end else begin
					r = 0;
					while (r < key_cnt && key_store[r] != key)
						r++;
					if (r >= key_cnt) begin
						w.status = ST_NOTFOUND;
					end else begin
						for (i = r; i + 1 < key_cnt; i++)
							key_store[i] = key_store[i+1];
						key_cnt--;
						w.position = r[POS_W-1:0];
					end
				end
				fresh_rsp.push_back(w);
			end
			OP_READ: begin
				if (key_cnt == 0) begin
					w.status = ST_EMPTY;
					fresh_rsp.push_back(w);
				end else begin
					for (i = 0; i < key_cnt; i++) begin
						w.key_out  = key_store[i];
						w.position = i[POS_W-1:0];
						w.last     = (i == key_cnt - 1);
						fresh_rsp.push_back(w);
					end
				end
			end
			default: ;
		endcase
	endfunction

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_cmd(input logic [OP_W-1:0] op, input logic signed [KEY_W-1:0] key,
			input bit typed, input status_t t_status, input logic [POS_W-1:0] t_pos);
		req_ch.valid <= 1'b1;
		req_ch.op    <= op;
		req_ch.key   <= key;
		do
			@(posedge clk);
		while (!req_ch.ready);
		predict_cmd(op, key);
		if (typed) begin
			fresh_rsp[0].status   = t_status;
			fresh_rsp[0].key_out  = key;
			fresh_rsp[0].position = t_pos;
			fresh_rsp[0].last     = 1'b1;
		end
		foreach (fresh_rsp[i]) begin
			if (fresh_rsp[i].status == ST_FULL)
				n_full++;
			words_due.push_back(fresh_rsp[i]);
		end
		fresh_rsp.delete();
		n_cmds++;
		if (op == OP_UNUSED)
			n_ignored++;
		if (op == OP_READ)
			n_reads++;
		if (key_cnt > peak_fill)
			peak_fill = key_cnt;
		@(negedge clk);
	endtask

	task automatic sender_gap();
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	function automatic logic signed [KEY_W-1:0] pick_key(input int src);
		if (src == 1 && key_cnt > 0)
			return key_store[$urandom_range(0, key_cnt - 1)];
		if (src == 2)
			return $urandom;
		return key_pool[$urandom_range(0, 23)];
	endfunction

	// stimulus and reset
	initial begin
		int                      row;
		int                      real_cnt;
		int                      burst;
		int                      b;
		int                      ep_left;
		int                      ins_w;
		int                      r;
		int                      k;
		logic [OP_W-1:0]         op;
		logic signed [KEY_W-1:0] key;
		arst_n       = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.op    = OP_INSERT;
		req_ch.key   = '0;
		key_cnt      = 0;
		real_cnt     = 0;
		ep_left      = 0;
		ins_w        = 45;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		row = 0;
		while (row < $size(script)) begin
			burst = $urandom_range(1, 6);
			for (b = 0; b < burst && row < $size(script); b++) begin
				send_cmd(script[row].op, script[row].key, script[row].typed,
					script[row].status, script[row].position);
				if (script[row].op != OP_UNUSED)
					real_cnt++;
				row++;
			end
			sender_gap();
		end

		key_pool[0] = 32'sh7FFFFFFF;
		key_pool[1] = 32'sh80000000;
		key_pool[2] = 32'sd0;
		key_pool[3] = -32'sd1;
		for (k = 4; k < 24; k++)
			key_pool[k] = (k < 12) ? $urandom_range(0, 40) - 20 : $urandom;

		hold_req = 1'b1;
		while (real_cnt < ITEMS) begin
			burst = $urandom_range(1, 12);
			for (b = 0; b < burst; b++) begin
				if (ep_left <= 0) begin
					ep_left = $urandom_range(15, 40);
					case ($urandom_range(0, 2))
						0: ins_w = 75;
						1: ins_w = 45;
						default: ins_w = 15;
					endcase
				end
				ep_left--;
				r = $urandom_range(0, 99);
				k = $urandom_range(0, 9);
				if (r < 3) begin
					op  = OP_UNUSED;
					key = $urandom;
				end else if (r < 11) begin
					op  = OP_READ;
					key = $urandom;
				end else if (r < 11 + ins_w) begin
					op  = OP_INSERT;
					key = pick_key((k < 6) ? 0 : (k < 8) ? 1 : 2);
				end else begin
					op  = OP_DELETE;
					key = pick_key((k < 6) ? 1 : (k < 9) ? 0 : 2);
				end
				send_cmd(op, key, 1'b0, ST_OK, '0);
				if (op != OP_UNUSED)
					real_cnt++;
			end
			sender_gap();
		end
		req_ch.valid <= 1'b0;

		while (words_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("ran %0d commands (%0d unused opcode, %0d readouts), %0d result words checked",
			n_cmds, n_ignored, n_reads, n_words);
		$display("peak fill %0d of %0d, %0d inserts refused as full, %0d mismatches",
			peak_fill, CAPACITY, n_full, err_cnt);
		if (err_cnt == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// receiver: stall patterns in stretches, one long hold-off
	initial begin
		int mode;
		int span;
		int k;
		rsp_ch.ready = 1'b0;
		hold_done    = 1'b0;
		@(posedge arst_n);
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(10, 150);
			for (k = 0; k < span; k++) begin
				@(negedge clk);
				if (hold_req && !hold_done) begin
					rsp_ch.ready <= 1'b0;
					repeat (HOLD_LEN) @(negedge clk);
					hold_done = 1'b1;
				end
				case (mode)
					0: rsp_ch.ready <= 1'b1;
					1: rsp_ch.ready <= ($urandom_range(0, 9) < 6);
					2: rsp_ch.ready <= (k % 4 == 0);
					default: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// each accepted word against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			n_words++;
			if (words_due.size() == 0) begin
				report_mismatch($sformatf("unexpected word: status %0d key %0d pos %0d last %0b",
					rsp_ch.status, rsp_ch.key_out, rsp_ch.position, rsp_ch.last));
			end else begin
				word_due = words_due.pop_front();
				if (rsp_ch.status !== word_due.status || rsp_ch.key_out !== word_due.key_out
						|| rsp_ch.position !== word_due.position
						|| rsp_ch.last !== word_due.last)
					report_mismatch($sformatf(
						"got st %0d key %0d pos %0d last %0b, want st %0d key %0d pos %0d last %0b",
						rsp_ch.status, rsp_ch.key_out, rsp_ch.position, rsp_ch.last,
						word_due.status, word_due.key_out, word_due.position,
						word_due.last));
			end
		end
	end

	initial begin
		#12_000_000;
		$display("timeout: %0d result words outstanding", words_due.size());
		$display("end of test: mismatches");
		$finish;
	end

endmodule

// File: sorted_unique_key_list.f
rtl/core/srtk_pkg.sv
rtl/core/srtk_if.sv
rtl/core/srtk_front.sv
rtl/core/srtk_back.sv
rtl/core/sorted_unique_key_list.sv
dv/sorted_unique_key_list_test.sv
